// ===== hdl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int BYTE_BITS    = 8;

  // Stored and applied code lengths never exceed this limit.
  localparam int CODE_LIM     = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 6;
  localparam int ENTRY_W      = VAL_W + LEN_W;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage
`default_nettype wire

// ===== hdl/hcbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [WIDTH-1:0]               wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic      [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: code table in RAM and an MSB-first bit packer.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel with a valid/ready handshake. A load
// transfer writes one code table entry, an encode transfer appends the
// symbol's code to the pending bits, and a flush transfer pads the pending
// bits with zeros to one byte. Completed bytes leave on the out_ channel, one
// per transfer, with out_last_of_run set on the last byte of an item.
// An encode reads the table RAM at its transfer edge into the merge stage.
// The entry is merged into the pending bits when the merge stage advances,
// and the emitter is loaded at that same edge; its first byte then passes
// through the output register.
// An item enters every cycle as long as the emitter can take its bytes. The
// emitter sends one byte per cycle while the receiver is ready, and it takes
// the next item's bytes only as its last queued byte leaves; an item yields up to four bytes.
// Reset clears the pending bits and all pipeline valid flags; the table RAM
// is not cleared and must be loaded before its entries are encoded.
// When the receiver stalls, the output register holds its byte, the emitter
// keeps its bytes, and in_ready drops once the merge stage cannot advance.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_action,
  input  wire logic [7:0]                      in_symbol,
  input  wire logic [31:0]                     in_code_bits,
  input  wire logic [5:0]                      in_code_length,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_last_of_run
);
  import hcbp_pkg::*;

  localparam logic [LEN_W-1:0] LenLim = LEN_W'(CODE_LIM);

  logic                 in_xfer;
  logic                 sym_in_range;
  logic [LEN_W-1:0]     load_len;
  logic                 ram_wr_en;
  logic                 ram_rd_en;
  logic [ENTRY_W-1:0]   ram_rd_data;

  logic                 s1_valid_r;
  logic [1:0]           s1_action_r;
  logic                 s1_in_range_r;

  logic [6:0]           pend_bits_r;
  logic [2:0]           pend_cnt_r;

  logic [31:0]          em_word_r;
  logic [2:0]           em_rem_r;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  logic [LEN_W-1:0]     rd_len;
  logic [LEN_W-1:0]     code_len;
  logic [63:0]          code_mask;
  logic [31:0]          code_val;
  logic [38:0]          acc;
  logic [5:0]           total;
  logic [2:0]           new_cnt;
  logic [6:0]           new_pend;
  logic [31:0]          enc_word;
  logic [2:0]           enc_nbytes;

  logic                 s1_is_enc;
  logic                 s1_is_flush;
  logic                 s1_emits;
  logic                 s1_updates;
  logic [31:0]          s1_word;
  logic [2:0]           s1_nbytes;
  logic                 s1_adv;

  logic                 out_take;
  logic                 em_pop;
  logic                 em_can_load;
  logic [7:0]           em_byte;

  // Input side and table RAM.
  assign in_xfer      = in_valid && in_ready;
  assign sym_in_range = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign load_len     = (in_code_length > LenLim) ? LenLim : in_code_length;
  assign ram_wr_en    = in_xfer && (in_action == ACT_LOAD) && sym_in_range;
  assign ram_rd_en    = in_xfer && (in_action == ACT_ENCODE);

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_symbol[ADDR_W-1:0]),
    .wr_data ({load_len, in_code_bits}),
    .rd_en   (ram_rd_en),
    .rd_addr (in_symbol[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Merge of the looked-up code into the pending bits.
  always_comb begin
    rd_len     = ram_rd_data[ENTRY_W-1 -: LEN_W];
    code_len   = (rd_len > LenLim) ? LenLim : rd_len;
    code_mask  = (64'd1 << code_len) - 64'd1;
    code_val   = ram_rd_data[VAL_W-1:0] & code_mask[31:0];
    acc        = ({32'd0, pend_bits_r} << code_len) | {7'd0, code_val};
    total      = {3'd0, pend_cnt_r} + code_len;
    new_cnt    = total[2:0];
    enc_nbytes = total[5:3];
    new_pend   = acc[6:0] & ((7'd1 << new_cnt) - 7'd1);
    enc_word   = 32'(acc >> new_cnt);
  end

  always_comb begin
    s1_is_enc   = s1_valid_r && (s1_action_r == ACT_ENCODE) && s1_in_range_r &&
                  (code_len != '0);
    s1_is_flush = s1_valid_r && (s1_action_r == ACT_FLUSH) && (pend_cnt_r != 3'd0);
    s1_updates  = s1_is_enc || s1_is_flush;
    s1_emits    = s1_is_flush || (s1_is_enc && (enc_nbytes != 3'd0));
    if (s1_is_flush) begin
      s1_word   = {24'd0, 8'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}))};
      s1_nbytes = 3'd1;
    end else begin
      s1_word   = enc_word;
      s1_nbytes = enc_nbytes;
    end
  end

  // Emitter and output register.
  assign out_take    = !out_valid_r || out_ready;
  assign em_pop      = (em_rem_r != 3'd0) && out_take;
  assign em_can_load = (em_rem_r == 3'd0) || ((em_rem_r == 3'd1) && out_take);
  assign s1_adv      = s1_valid_r && (!s1_emits || em_can_load);
  assign in_ready    = !s1_valid_r || s1_adv;

  always_comb begin
    case (em_rem_r)
      3'd1:    em_byte = em_word_r[7:0];
      3'd2:    em_byte = em_word_r[15:8];
      3'd3:    em_byte = em_word_r[23:16];
      3'd4:    em_byte = em_word_r[31:24];
      default: em_byte = em_word_r[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      em_rem_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_xfer;
      end
      if (s1_adv && s1_is_enc) begin
        pend_bits_r <= new_pend;
        pend_cnt_r  <= new_cnt;
      end else if (s1_adv && s1_is_flush) begin
        pend_bits_r <= '0;
        pend_cnt_r  <= '0;
      end
      if (s1_adv && s1_emits) begin
        em_rem_r <= s1_nbytes;
      end else if (em_pop) begin
        em_rem_r <= em_rem_r - 3'd1;
      end
      if (out_take) begin
        out_valid_r <= em_pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r   <= in_action;
      s1_in_range_r <= sym_in_range;
    end
    if (s1_adv && s1_emits) begin
      em_word_r <= s1_word;
    end
    if (em_pop) begin
      out_byte_r <= em_byte;
      out_last_r <= (em_rem_r == 3'd1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`ifndef NO_ASSERTIONS
  a_em_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    em_rem_r <= 3'd4)
    else $error("Emitter holds more than four bytes.");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_is_flush) |=> (pend_cnt_r == 3'd0))
    else $error("Pending bits remain after a flush.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("Input stalled with an empty merge stage.");

  a_no_load_over_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emits) |-> ((em_rem_r == 3'd0) || (em_rem_r == 3'd1 && em_pop)))
    else $error("Emitter reloaded while bytes were still queued.");
`endif

endmodule
`default_nettype wire
